### hw/rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the signed decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH  = 8;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_WIDTH-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] MINUS_CODE = 8'd45;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_WIDTH - 1);
    localparam logic [DIG_CNT_W-1:0] ALL_DIGITS = DIG_CNT_W'(NUM_DIGITS);
    localparam logic [DIG_CNT_W-1:0] ONE_DIGIT  = DIG_CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_SKIP  = 4'b0100,
        S_DIGIT = 4'b1000
    } state_t;

endpackage

### hw/rtl/signed_decimal_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// Converts a signed 32-bit integer to decimal ASCII text, issued one byte per cycle once converted.
//
// Usage: drive value and raise start while busy is low; that edge is the
// transfer. busy stays high until the last character has been issued.
// The magnitude is converted by a bit-serial double-dabble shifter, one
// input bit per cycle, then leading zero digits are dropped at one per
// cycle (up to 9), then the text is issued one byte per cycle:
// a minus sign for negative values, then the digits, most significant first.
// Each character is on char_code/last for exactly one cycle with strobe high;
// last marks the final character. The receiver cannot stall the output.
// The conversion shifter takes up most of the item time. For a negative
// value the minus sign comes in the cycle before the first digit. A new
// item may be started in the cycle the last character is shown. Reset
// returns the block to idle and drops any conversion in progress; no state
// is kept between items.
// ----------------------------------------------------------------------------
module signed_decimal_formatter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sdf_pkg::VALUE_WIDTH-1:0] value,
    output logic                                strobe,
    output logic        [sdf_pkg::CHAR_WIDTH-1:0]  char_code,
    output logic                                last
);

    sdf_pkg::state_t state_reg, state_next;

    logic [sdf_pkg::VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [sdf_pkg::BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [sdf_pkg::BCD_WIDTH-1:0]   bcd_adj;
    logic [sdf_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [sdf_pkg::DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                            neg_reg, neg_next;
    logic                            strobe_reg, strobe_next;
    logic                            last_reg, last_next;
    logic [sdf_pkg::CHAR_WIDTH-1:0]  char_reg, char_next;
    logic [3:0]                      top_digit;
    logic [sdf_pkg::VALUE_WIDTH-1:0] raw;

    assign raw       = sdf_pkg::VALUE_WIDTH'(value);
    assign top_digit = bcd_reg[sdf_pkg::BCD_WIDTH-1 -: 4];

    // add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        char_next    = char_reg;

        case (state_reg)
            sdf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    neg_next     = raw[sdf_pkg::VALUE_WIDTH-1];
                    mag_next     = raw[sdf_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = sdf_pkg::S_CONV;
                end
            end
            sdf_pkg::S_CONV:
            begin
                bcd_next     = {bcd_adj[sdf_pkg::BCD_WIDTH-2:0],
                                mag_reg[sdf_pkg::VALUE_WIDTH-1]};
                mag_next     = {mag_reg[sdf_pkg::VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sdf_pkg::LAST_BIT)
                begin
                    dig_cnt_next = sdf_pkg::ALL_DIGITS;
                    state_next   = sdf_pkg::S_SKIP;
                end
            end
            sdf_pkg::S_SKIP:
            begin
                if (top_digit == 4'd0 && dig_cnt_reg != sdf_pkg::ONE_DIGIT)
                begin
                    bcd_next     = {bcd_reg[sdf_pkg::BCD_WIDTH-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    if (neg_reg)
                    begin
                        strobe_next = 1'b1;
                        char_next   = sdf_pkg::MINUS_CODE;
                    end
                    state_next = sdf_pkg::S_DIGIT;
                end
            end
            sdf_pkg::S_DIGIT:
            begin
                strobe_next  = 1'b1;
                char_next    = sdf_pkg::DIGIT_BASE + {4'd0, top_digit};
                bcd_next     = {bcd_reg[sdf_pkg::BCD_WIDTH-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - 1'b1;
                if (dig_cnt_reg == sdf_pkg::ONE_DIGIT)
                begin
                    last_next  = 1'b1;
                    state_next = sdf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sdf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sdf_pkg::S_IDLE;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
    end

    assign busy      = (state_reg != sdf_pkg::S_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    a_last_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("block still busy after final character");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start a conversion");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == sdf_pkg::MINUS_CODE) |-> !last)
        else $error("minus sign flagged as final character");

    a_no_output_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdf_pkg::S_CONV) |=> !strobe)
        else $error("character issued during conversion");

endmodule
